[sv/mpe_pkg.sv]
// ----------------------------------------------------------------------------
// mpe_pkg: shared types and constants of the mask perimeter extractor
// Grid limits, field widths, the opcode codes and the result point type.
// ----------------------------------------------------------------------------
`default_nettype none

package mpe_pkg;

   // Largest grid side; sets the depth of the line memory
   localparam int MAX_GRID = 256;
   localparam int MIN_GRID = 3;
   localparam int ADDR_W   = $clog2(MAX_GRID);

   // Field widths
   localparam int GRID_W   = 9;
   localparam int OPCODE_W = 1;
   localparam int COORD_W  = 8;
   localparam int INDEX_W  = 16;
   localparam int COUNT_W  = 17;

   // Line memory word: cell and shape one row up, shape two rows up
   localparam int LB_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PIXEL = 1'b0,
      OP_FILL  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [INDEX_W-1:0] list_index;
   } point_type;

endpackage

`default_nettype wire

[sv/mpe_chan_if.sv]
// ----------------------------------------------------------------------------
// mpe_chan_if: valid/ready channels of the mask perimeter extractor
// Pixel request channel and perimeter point response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpe_req_if;
   import mpe_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic                cell_full;
   logic                shape_full;

   modport source (output valid, output opcode, output cell_full, output shape_full,
                   input ready);
   modport sink   (input valid, input opcode, input cell_full, input shape_full,
                   output ready);
endinterface

interface mpe_rsp_if;
   import mpe_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [INDEX_W-1:0] list_index;

   modport source (output valid, output row, output col, output list_index,
                   input ready);
   modport sink   (input valid, input row, input col, input list_index,
                   output ready);
endinterface

`default_nettype wire

[sv/mpe_line_ram.sv]
// ----------------------------------------------------------------------------
// mpe_line_ram: one write port, one read port line memory
// Read data is registered and returns the old contents on an address match.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_line_ram #(
   parameter int DATA_W = 3,
   parameter int DEPTH  = 256
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/mpe_rsp_buf.sv]
// ----------------------------------------------------------------------------
// mpe_rsp_buf: two-entry output buffer for perimeter points
// Output register plus skid entry; full only while both hold a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mpe_pkg::point_type push_data,
   output logic               full,
   mpe_rsp_if.source          rsp_bus
);
   import mpe_pkg::*;

   logic      out_v_ff, out_v_in;
   logic      skid_v_ff, skid_v_in;
   point_type out_ff, out_in;
   point_type skid_ff, skid_in;
   logic      pop;

   assign pop = out_v_ff && rsp_bus.ready;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = push;
            skid_in   = push_data;
         end else begin
            out_v_in  = push;
            out_in    = push_data;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         // head is stalled: park the new beat
         skid_v_in = 1'b1;
         skid_in   = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full               = skid_v_ff;
   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.row        = out_ff.row;
   assign rsp_bus.col        = out_ff.col;
   assign rsp_bus.list_index = out_ff.list_index;

   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry holds a beat while the head is empty");

   a_stalled_push_parks: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_bus.ready && push) |=> skid_v_ff)
      else $error("beat pushed behind a stalled head was lost");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !pop) |-> !push)
      else $error("beat pushed into a full buffer");

endmodule

`default_nettype wire

[sv/mask_perimeter_extractor.sv]
// ----------------------------------------------------------------------------
// mask_perimeter_extractor: 8-neighbour perimeter points of a binary mask
// Streams cell and shape mask pixels in raster order and emits the perimeter.
// ----------------------------------------------------------------------------
// One item is taken per clock. A position is decided when the item
// grid_size+1 places later in the stream is taken, so a frame needs
// grid_size+1 filler beats after its last pixel; any beat in that drain part
// counts as empty. The decision is made in the accept cycle from a 3x3 window
// built from the registered read of a single line memory (two shape rows and
// one cell row, indexed by column) and two window column registers, and the
// point reaches rsp through a register. A two-entry output buffer lets intake
// continue under a stalled response; intake stops only while both entries are
// full. Fillers inside the pixel part are taken and dropped. A grid_size write
// clamps to 3..256 and restarts the frame and the point count.
// ----------------------------------------------------------------------------
`default_nettype none

module mask_perimeter_extractor (
   input  logic                        clock,
   input  logic                        reset,
   mpe_req_if.sink                     req_bus,
   mpe_rsp_if.source                   rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [mpe_pkg::GRID_W-1:0]  csr_wr_data
);
   import mpe_pkg::*;

   typedef struct packed {
      logic cell1;
      logic shape2;
      logic shape1;
   } lb_word_type;

   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } win_col_type;

   logic [GRID_W-1:0]  size_ff, size_in, size_clamp, size_m1;
   logic [GRID_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0]  col_ff, col_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   win_col_type        col_a_ff, col_b_ff;
   logic               cell_a_ff;

   lb_word_type        rd_word, wr_word;
   logic [LB_W-1:0]    rd_bits;
   logic               accept, draining, advance, last_pos, col_last, col_zero;
   logic [GRID_W-1:0]  q_row;
   logic [ADDR_W-1:0]  q_col;
   logic               q_valid, up_ok, dn_ok, lf_ok, rt_ok;
   logic               s_new, c_new, on_edge, produced, buf_full;
   logic [7:0]         nb;
   point_type          point;

   assign accept   = req_bus.valid && req_bus.ready;
   assign draining = row_ff >= size_ff;
   assign advance  = accept && (draining || opcode_type'(req_bus.opcode) == OP_PIXEL);
   assign last_pos = row_ff == size_ff + GRID_W'(1);
   assign size_m1  = size_ff - GRID_W'(1);
   assign col_last = GRID_W'(col_ff) == size_m1;
   assign col_zero = col_ff == '0;

   always_comb begin
      size_clamp = csr_wr_data;
      if (csr_wr_data < GRID_W'(MIN_GRID)) begin
         size_clamp = GRID_W'(MIN_GRID);
      end else if (csr_wr_data > GRID_W'(MAX_GRID)) begin
         size_clamp = GRID_W'(MAX_GRID);
      end
   end

   // Decided position lies grid_size+1 beats behind the incoming one
   assign q_row   = col_zero ? row_ff - GRID_W'(2) : row_ff - GRID_W'(1);
   assign q_col   = col_zero ? size_m1[ADDR_W-1:0] : col_ff - ADDR_W'(1);
   assign q_valid = (row_ff >= GRID_W'(2)) || (row_ff == GRID_W'(1) && !col_zero);

   assign up_ok = q_row != '0;
   assign dn_ok = q_row != size_m1;
   assign lf_ok = q_col != '0;
   assign rt_ok = GRID_W'(q_col) != size_m1;

   assign s_new = !draining && req_bus.shape_full;
   assign c_new = !draining && req_bus.cell_full;

   assign rd_word = lb_word_type'(rd_bits);

   // Off-grid neighbours read as empty
   assign nb[0] = up_ok && lf_ok && col_b_ff.top;
   assign nb[1] = up_ok && col_a_ff.top;
   assign nb[2] = up_ok && rt_ok && rd_word.shape2;
   assign nb[3] = lf_ok && col_b_ff.mid;
   assign nb[4] = rt_ok && rd_word.shape1;
   assign nb[5] = dn_ok && lf_ok && col_b_ff.bot;
   assign nb[6] = dn_ok && col_a_ff.bot;
   assign nb[7] = dn_ok && rt_ok && s_new;

   assign on_edge  = ~&nb;
   assign produced = advance && q_valid && cell_a_ff && on_edge;

   assign point.row        = COORD_W'(q_row);
   assign point.col        = COORD_W'(q_col);
   assign point.list_index = count_ff[INDEX_W-1:0];

   assign wr_word.cell1  = c_new;
   assign wr_word.shape2 = rd_word.shape1;
   assign wr_word.shape1 = s_new;

   always_comb begin
      size_in  = size_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         size_in  = size_clamp;
         row_in   = '0;
         col_in   = '0;
         count_in = '0;
      end else if (advance) begin
         if (last_pos) begin
            // end of drain: wrap to the next frame
            row_in   = '0;
            col_in   = '0;
            count_in = '0;
         end else begin
            count_in = count_ff + COUNT_W'(produced);
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + GRID_W'(1);
            end else begin
               col_in = col_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= GRID_W'(MAX_GRID);
         row_ff   <= '0;
         col_ff   <= '0;
         count_ff <= '0;
      end else begin
         size_ff  <= size_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         count_ff <= count_in;
      end
   end

   // Shift the window one column
   always_ff @(posedge clock) begin
      if (advance) begin
         col_b_ff  <= col_a_ff;
         col_a_ff  <= '{top: rd_word.shape2, mid: rd_word.shape1, bot: s_new};
         cell_a_ff <= rd_word.cell1;
      end
   end

   mpe_line_ram #(
      .DATA_W (LB_W),
      .DEPTH  (MAX_GRID)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (col_ff),
      .wr_data (wr_word),
      .rd_addr (col_in),
      .rd_data (rd_bits)
   );

   mpe_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (produced),
      .push_data (point),
      .full      (buf_full),
      .rsp_bus   (rsp_bus)
   );

   assign req_bus.ready = !buf_full;

   a_hold_on_dropped_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && !advance && !csr_wr_en) |=> (row_ff == $past(row_ff) &&
                                             col_ff == $past(col_ff)))
      else $error("filler inside the pixel part moved the position");

   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      GRID_W'(col_ff) < size_ff)
      else $error("column counter beyond grid size");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= size_ff + GRID_W'(1))
      else $error("row counter beyond drain rows");

   a_point_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      produced |-> (q_valid && !(row_ff == '0)))
      else $error("point emitted before its position is decided");

endmodule

`default_nettype wire

[sim/mask_perimeter_extractor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_perimeter_extractor_tb: self-checking bench for the perimeter extractor
// Streams cell and shape mask pixels over several grid sizes, tracks the
// raster position and pixel history alongside the block to work out which
// points lie on the perimeter, and checks every response beat in order.
// ----------------------------------------------------------------------------

module mask_perimeter_extractor_tb;
   import mpe_pkg::*;

   localparam int CLK_PERIOD       = 10;
   localparam int HIST_DEPTH       = 2 * MAX_GRID + 3;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SMALL_BEATS      = 150;
   localparam int MAX_REPORTS      = 10;
   localparam int TIMEOUT_NS       = 1_000_000;

   typedef struct packed {
      opcode_type opcode;
      logic       cell_full;
      logic       shape_full;
   } mask_beat_type;

   typedef enum logic [1:0] {
      RDY_STEADY,
      RDY_COIN,
      RDY_SPARSE
   } ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [GRID_W-1:0]     csr_wr_data;

   mpe_req_if req_bus ();
   mpe_rsp_if rsp_bus ();

   mask_perimeter_extractor dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Shadow of the block: raster position, pixel history and point count
   int                    grid_side = MAX_GRID;
   int                    cur_row;
   int                    cur_col;
   logic [COUNT_W-1:0]    point_count;
   bit                    cell_hist  [HIST_DEPTH];
   bit                    shape_hist [HIST_DEPTH];

   point_type             points_due [$];
   mask_beat_type         pending_beats [$];
   mask_beat_type         beat_on_bus;
   int                    beats_queued;
   int                    beats_taken;
   int                    fault_count;

   int                    gap_left;
   int                    burst_left;
   int                    hold_left;
   int                    mode_left;
   ready_mode_type        ready_mode;
   logic                  long_hold_req   = 1'b0;
   logic                  long_hold_taken = 1'b0;

   // Advance the shadow by one accepted beat and queue the point it decides
   task automatic track_pixel(input mask_beat_type beat);
      int        side, npix, pos, q, r, c, nr, nc;
      bit        on_border;
      point_type pt;
      side = grid_side;
      npix = side * side;
      pos  = cur_row * side + cur_col;
      if (pos < npix) begin
         if (beat.opcode == OP_FILL) return;
         cell_hist[pos % HIST_DEPTH]  = beat.cell_full;
         shape_hist[pos % HIST_DEPTH] = beat.shape_full;
      end else begin
         // drain part: data ignored, counts as empty
         cell_hist[pos % HIST_DEPTH]  = 1'b0;
         shape_hist[pos % HIST_DEPTH] = 1'b0;
      end
      if (pos >= side + 1) begin
         q = pos - side - 1;
         r = q / side;
         c = q % side;
         if (cell_hist[q % HIST_DEPTH]) begin
            on_border = 1'b0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if (dr == 0 && dc == 0) continue;
                  if (nr < 0 || nc < 0 || nr >= side || nc >= side)
                     on_border = 1'b1;
                  else if (!shape_hist[(nr * side + nc) % HIST_DEPTH])
                     on_border = 1'b1;
               end
            end
            if (on_border) begin
               pt.row        = COORD_W'(r);
               pt.col        = COORD_W'(c);
               pt.list_index = point_count[INDEX_W-1:0];
               points_due.push_back(pt);
               point_count = point_count + 1'b1;
            end
         end
      end
      pos++;
      if (pos >= npix + side + 1) begin
         cur_row     = 0;
         cur_col     = 0;
         point_count = '0;
      end else begin
         cur_col++;
         if (cur_col >= side) begin
            cur_col = 0;
            cur_row++;
         end
      end
   endtask

   task automatic log_fault(input string what, input point_type due, input point_type seen);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s: expected row %0d col %0d index %0d, got row %0d col %0d index %0d",
                  $time, what, due.row, due.col, due.list_index,
                  seen.row, seen.col, seen.list_index);
   endtask

   task automatic push_beat(input opcode_type op, input bit cell_bit, input bit shape_bit);
      mask_beat_type b;
      b.opcode     = op;
      b.cell_full  = cell_bit;
      b.shape_full = shape_bit;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic wait_for_quiet();
      do @(posedge clock);
      while (beats_taken != beats_queued || points_due.size() != 0);
   endtask

   task automatic program_grid(input logic [GRID_W-1:0] raw);
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (int'(raw) < MIN_GRID)
         grid_side = MIN_GRID;
      else if (int'(raw) > MAX_GRID)
         grid_side = MAX_GRID;
      else
         grid_side = int'(raw);
      cur_row     = 0;
      cur_col     = 0;
      point_count = '0;
   endtask

   // Queue a frame (or its first beats) with random mask content
   task automatic queue_frame(input int side, input int beats, input int cell_pct,
                              input int shape_pct, input int fill_pct, input bit pause_mid);
      int npix;
      npix = side * side;
      for (int pos = 0; pos < beats; pos++) begin
         if (pause_mid && pos == beats / 2) wait_for_quiet();
         if (pos < npix) begin
            if ($urandom_range(0, 99) < fill_pct)
               push_beat(OP_FILL, bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
            push_beat(OP_PIXEL, $urandom_range(0, 99) < cell_pct,
                      $urandom_range(0, 99) < shape_pct);
         end else begin
            push_beat($urandom_range(0, 1) ? OP_FILL : OP_PIXEL,
                      bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
         end
      end
   endtask

   // Request driver: bursts of beats with random gaps in between
   always @(posedge clock) begin
      mask_beat_type next_beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left      <= 0;
         burst_left    <= $urandom_range(1, 40);
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            track_pixel(beat_on_bus);
            beats_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               next_beat          = pending_beats.pop_front();
               beat_on_bus        <= next_beat;
               req_bus.valid      <= 1'b1;
               req_bus.opcode     <= next_beat.opcode;
               req_bus.cell_full  <= next_beat.cell_full;
               req_bus.shape_full <= next_beat.shape_full;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stall modes, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready   <= 1'b0;
         hold_left       <= 0;
         mode_left       <= 0;
         ready_mode      <= RDY_STEADY;
         long_hold_taken <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (long_hold_req && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_left       <= LONG_HOLD_CYCLES;
         rsp_bus.ready   <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 2));
            mode_left  <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            RDY_STEADY: rsp_bus.ready <= 1'b1;
            RDY_COIN:   rsp_bus.ready <= bit'($urandom_range(0, 1));
            default:    rsp_bus.ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Response monitor: each point beat against the oldest point due
   always @(posedge clock) begin
      point_type seen, due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.row        = rsp_bus.row;
         seen.col        = rsp_bus.col;
         seen.list_index = rsp_bus.list_index;
         if (points_due.size() == 0) begin
            log_fault("point with none due", '0, seen);
         end else begin
            due = points_due.pop_front();
            if (seen.row !== due.row || seen.col !== due.col ||
                seen.list_index !== due.list_index)
               log_fault("wrong point", due, seen);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("mask_perimeter_extractor: mismatch");
      $finish;
   end

   initial begin
      int                small_beats, side, beats, frames, pct_c, pct_s;
      logic [GRID_W-1:0] raw;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_PIXEL;
      req_bus.cell_full  = 1'b0;
      req_bus.shape_full = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Smallest grid: a full frame of ones, with a filler inside the pixel
      // part and a pixel opcode in the drain part; then shape all empty
      program_grid('0);
      for (int i = 0; i < 9; i++) begin
         push_beat(OP_PIXEL, 1'b1, 1'b1);
         if (i == 0) push_beat(OP_FILL, 1'b1, 1'b0);
      end
      push_beat(OP_PIXEL, 1'b1, 1'b1);
      repeat (3) push_beat(OP_FILL, 1'b1, 1'b0);
      for (int i = 0; i < 9; i++) push_beat(OP_PIXEL, 1'b1, 1'b0);
      repeat (4) push_beat(OP_FILL, 1'b0, 1'b1);

      // Every pixel a point while the response side holds off
      program_grid(9'd4);
      long_hold_req <= 1'b1;
      repeat (3) queue_frame(4, 21, 100, 0, 0, 1'b0);

      // Widest grid through a clamped write: first two rows and a bit of the third
      program_grid('1);
      queue_frame(MAX_GRID, 2 * MAX_GRID + 8, 90, 90, 3, 1'b0);

      small_beats = 0;
      for (int n = 0; small_beats < SMALL_BEATS; n++) begin
         if (n < 2)
            raw = GRID_W'(n + 1);
         else if ($urandom_range(0, 3) == 0)
            raw = GRID_W'($urandom_range(9, 16));
         else
            raw = GRID_W'($urandom_range(3, 8));
         program_grid(raw);
         side   = (int'(raw) < MIN_GRID) ? MIN_GRID : int'(raw);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            beats = side * side + side + 1;
            // abandon the last frame now and then
            if (f == frames - 1 && $urandom_range(0, 3) == 0)
               beats = $urandom_range(1, beats - 1);
            pct_c = ($urandom_range(0, 2) == 0) ? 100 * $urandom_range(0, 1)
                                                : $urandom_range(10, 95);
            pct_s = ($urandom_range(0, 2) == 0) ? 100 * $urandom_range(0, 1)
                                                : $urandom_range(10, 95);
            queue_frame(side, beats, pct_c, pct_s, 5,
                        n == 0 || $urandom_range(0, 5) == 0);
            small_beats += beats;
         end
      end

      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && points_due.size() == 0)
         $display("mask_perimeter_extractor: match");
      else
         $display("mask_perimeter_extractor: mismatch");
      $finish;
   end

endmodule
